// File: sv/assert_macros.svh
// assertion helpers for the rtl files, included by grwh_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define GRWH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition implies consequence on the following edge
`define GRWH_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/grwh_pkg.sv
// ----------------------------------------------------------------------------
// grwh_pkg
// shared constants, tables, types and helpers of the grid ray wall hit unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package grwh_pkg;

	localparam int GRID_DIM   = 9;
	// cell edge in world units, a power of two
	localparam int CELL_SIZE  = 64;
	localparam int CELL_SHIFT = $clog2(CELL_SIZE) + 6;

	localparam int DEPTH_W    = 5;
	localparam int ANG_W      = 9;
	localparam int IN_POS_W   = 16;
	localparam int CELL_IDX_W = 7;
	localparam int OUT_POS_W  = 17;
	localparam int POS_W      = 24;
	localparam int PROD_W     = 2 * POS_W;
	localparam int DIST_W     = 2 * POS_W;
	localparam int TAN_W      = 16;

	// item kinds carried on the action field
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(10);
	localparam logic signed [POS_W-1:0] CS = POS_W'(1) << CELL_SHIFT;

	localparam logic [TAN_W-1:0] TAN_Q88 [91] = '{
		16'd0, 16'd4, 16'd9, 16'd13, 16'd18, 16'd22, 16'd27, 16'd31, 16'd36, 16'd41,
		16'd45, 16'd50, 16'd54, 16'd59, 16'd64, 16'd69, 16'd73, 16'd78, 16'd83, 16'd88,
		16'd93, 16'd98, 16'd103, 16'd109, 16'd114, 16'd119, 16'd125, 16'd130, 16'd136,
		16'd142, 16'd148, 16'd154, 16'd160, 16'd166, 16'd173, 16'd179, 16'd186, 16'd193,
		16'd200, 16'd207, 16'd215, 16'd223, 16'd231, 16'd239, 16'd247, 16'd256, 16'd265,
		16'd275, 16'd284, 16'd294, 16'd305, 16'd316, 16'd328, 16'd340, 16'd352, 16'd366,
		16'd380, 16'd394, 16'd410, 16'd426, 16'd443, 16'd462, 16'd481, 16'd502, 16'd525,
		16'd549, 16'd575, 16'd603, 16'd634, 16'd667, 16'd703, 16'd743, 16'd788, 16'd837,
		16'd893, 16'd955, 16'd1027, 16'd1109, 16'd1204, 16'd1317, 16'd1452, 16'd1616,
		16'd1822, 16'd2085, 16'd2436, 16'd2926, 16'd3661, 16'd4885, 16'd7331, 16'd14666,
		16'd32767
	};

	typedef struct packed {
		logic                  en;
		logic [CELL_IDX_W-1:0] idx;
		logic                  wall;
	} grid_wr_t;

	typedef struct packed {
		logic                  en;
		logic [CELL_IDX_W-1:0] idx;
	} grid_rd_t;

	typedef struct packed {
		logic signed [POS_W-1:0] a;
		logic signed [POS_W-1:0] b;
	} mul_req_t;

	// angle already below 360
	function automatic logic signed [TAN_W-1:0] tan_of(input logic [ANG_W-1:0] ang);
		logic [ANG_W-1:0] q;
		q = (ang >= ANG_W'(180)) ? ang - ANG_W'(180) : ang;
		if (q <= ANG_W'(90))
			return TAN_Q88[q[6:0]];
		else
			return -TAN_Q88[7'(ANG_W'(180) - q)];
	endfunction

	function automatic logic signed [TAN_W-1:0] cot_of(input logic [ANG_W-1:0] ang);
		logic [ANG_W-1:0] q;
		q = (ang >= ANG_W'(180)) ? ang - ANG_W'(180) : ang;
		if (q <= ANG_W'(90))
			return TAN_Q88[7'(ANG_W'(90) - q)];
		else
			return -TAN_Q88[7'(q - ANG_W'(90))];
	endfunction

	// q8.8 product scaled back, rounding toward zero
	function automatic logic signed [POS_W-1:0] q88_trunc(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p[PROD_W-1] ? p + PROD_W'(255) : p;
		return POS_W'(t >>> 8);
	endfunction

	function automatic logic [OUT_POS_W-1:0] sat17(input logic signed [POS_W-1:0] v);
		if (v > POS_W'(65535))
			return OUT_POS_W'(65535);
		else if (v < -POS_W'(65536))
			return OUT_POS_W'(17'h10000);
		else
			return v[OUT_POS_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: sv/grwh_grid.sv
// ----------------------------------------------------------------------------
// grwh_grid
// wall bit store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grwh_grid #(
	parameter int GRID_DIM = grwh_pkg::GRID_DIM
) (
	input  logic               clk,
	input  logic               arst_n,
	input  grwh_pkg::grid_wr_t wr,
	input  grwh_pkg::grid_rd_t rd,
	output logic               rd_bit
);
	import grwh_pkg::*;

	localparam int CELLS = GRID_DIM * GRID_DIM;
	localparam int IDX_W = $clog2(CELLS);

	logic [CELLS-1:0] cell_q;
	logic             rd_bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (wr.en && wr.idx < CELL_IDX_W'(CELLS)) begin
			cell_q[wr.idx[IDX_W-1:0]] <= wr.wall;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_bit_q <= cell_q[rd.idx[IDX_W-1:0]];
		end
	end

	assign rd_bit = rd_bit_q;
endmodule
`default_nettype wire

// File: sv/grwh_mul.sv
// ----------------------------------------------------------------------------
// grwh_mul
// shared signed multiplier, result registered in the cycle after the request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grwh_mul (
	input  logic                                  clk,
	input  grwh_pkg::mul_req_t                    req,
	output logic signed [grwh_pkg::PROD_W-1:0]    p
);
	import grwh_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(req.a) * PROD_W'(req.b);
	end

	assign p = p_q;
endmodule
`default_nettype wire

// File: sv/grwh_ctrl.sv
// ----------------------------------------------------------------------------
// grwh_ctrl
// sequencer: cell writes, setup, grid line stepping and distance compare of one or both passes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module grwh_ctrl #(
	parameter int GRID_DIM = grwh_pkg::GRID_DIM
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [grwh_pkg::DEPTH_W-1:0]         depth,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 in_action,
	input  logic [grwh_pkg::CELL_IDX_W-1:0]      in_cell_index,
	input  logic                                 in_cell_wall,
	input  logic [grwh_pkg::IN_POS_W-1:0]        in_pos_x,
	input  logic [grwh_pkg::IN_POS_W-1:0]        in_pos_y,
	input  logic [grwh_pkg::ANG_W-1:0]           in_view_angle,
	output grwh_pkg::grid_wr_t                   grid_wr,
	output grwh_pkg::grid_rd_t                   grid_rd,
	input  logic                                 grid_bit,
	output grwh_pkg::mul_req_t                   mul_req,
	input  logic signed [grwh_pkg::PROD_W-1:0]   mul_p,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [grwh_pkg::OUT_POS_W-1:0]       hit_x,
	output logic [grwh_pkg::OUT_POS_W-1:0]       hit_y,
	output logic                                 hit_side,
	output logic                                 wall_found
);
	import grwh_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_MUL1 = 10'b0000000010,
		ST_MUL2 = 10'b0000000100,
		ST_MUL3 = 10'b0000001000,
		ST_CHK  = 10'b0000010000,
		ST_RD   = 10'b0000100000,
		ST_D1   = 10'b0001000000,
		ST_D2   = 10'b0010000000,
		ST_D3   = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	localparam logic signed [POS_W-1:0] GD = POS_W'(GRID_DIM);

	state_t state_q;
	logic   pass_q, up_q, right_q, hok_q, vok_q, hit_q, hhit_q;
	logic [ANG_W-1:0]         ang_q;
	logic [DEPTH_W-1:0]       cnt_q;
	logic signed [POS_W-1:0]  px_q, py_q, x_q, y_q, sx_q, sy_q, hx_q, hy_q;
	logic [DIST_W-1:0]        acc_q, hd_q, vd_q;
	logic                     out_valid_q, oside_q, owall_q;
	logic [OUT_POS_W-1:0]     ox_q, oy_q;

	logic [ANG_W-1:0]         ang_n;
	logic signed [TAN_W-1:0]  k;
	logic signed [POS_W-1:0]  d, s, r, cx, cy, dx, dy;
	logic [CELL_SHIFT-1:0]    frac;
	logic                     off, out_free, pick_h, out_load;
	logic [DIST_W-1:0]        dist_sum;

	assign ang_n = (in_view_angle >= ANG_W'(360)) ? in_view_angle - ANG_W'(360) : in_view_angle;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == ST_DONE) && out_free;

	// pass 0 walks horizontal lines with cot, pass 1 vertical lines with tan
	assign k    = pass_q ? tan_of(ang_q) : cot_of(ang_q);
	assign frac = pass_q ? px_q[CELL_SHIFT-1:0] : py_q[CELL_SHIFT-1:0];
	assign d    = ((pass_q ? right_q : !up_q) ? CS : '0) - POS_W'(frac);
	assign s    = (pass_q ? !right_q : up_q) ? -CS : CS;
	assign r    = q88_trunc(mul_p);

	assign cx  = (x_q >>> CELL_SHIFT) - $signed(POS_W'(pass_q && !right_q));
	assign cy  = (y_q >>> CELL_SHIFT) - $signed(POS_W'(!pass_q && up_q));
	assign off = (cx < 0) || (cy < 0) || (cx >= GD) || (cy >= GD);
	assign dx  = x_q - px_q;
	assign dy  = y_q - py_q;
	assign dist_sum = acc_q + DIST_W'(mul_p);
	assign pick_h = hok_q && (!vok_q || hd_q < vd_q);

	always_comb begin
		mul_req = '0;
		case (state_q)
			ST_MUL1: begin
				mul_req.a = pass_q ? d : -d;
				mul_req.b = POS_W'(k);
			end
			ST_MUL2: begin
				mul_req.a = pass_q ? s : -s;
				mul_req.b = POS_W'(k);
			end
			ST_D1: begin
				mul_req.a = dx;
				mul_req.b = dx;
			end
			ST_D2: begin
				mul_req.a = dy;
				mul_req.b = dy;
			end
			default: mul_req = '0;
		endcase
	end

	always_comb begin
		grid_wr.en   = in_valid && in_ready && (in_action == ACT_WRITE);
		grid_wr.idx  = in_cell_index;
		grid_wr.wall = in_cell_wall;
		grid_rd.en   = (state_q == ST_CHK) && (cnt_q != depth) && !off;
		grid_rd.idx  = CELL_IDX_W'(cy[CELL_IDX_W-1:0] * CELL_IDX_W'(GRID_DIM)
			+ cx[CELL_IDX_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_action == ACT_CAST)
						state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_CHK;
				ST_CHK: begin
					if (cnt_q == depth || off)
						state_q <= ST_D1;
					else
						state_q <= ST_RD;
				end
				ST_RD: state_q <= grid_bit ? ST_D1 : ST_CHK;
				ST_D1: state_q <= ST_D2;
				ST_D2: state_q <= ST_D3;
				ST_D3: state_q <= (!pass_q && vok_q) ? ST_MUL1 : ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q    <= POS_W'(in_pos_x);
				py_q    <= POS_W'(in_pos_y);
				ang_q   <= ang_n;
				up_q    <= ang_n < ANG_W'(180);
				right_q <= !(ang_n > ANG_W'(90) && ang_n < ANG_W'(270));
				hok_q   <= tan_of(ang_n) != '0;
				vok_q   <= ang_n != ANG_W'(90) && ang_n != ANG_W'(270);
				pass_q  <= tan_of(ang_n) == '0;
			end
			ST_MUL2: begin
				x_q <= pass_q ? px_q + d : px_q + r;
				y_q <= pass_q ? py_q - r : py_q + d;
			end
			ST_MUL3: begin
				sx_q  <= pass_q ? s : r;
				sy_q  <= pass_q ? -r : s;
				cnt_q <= '0;
				hit_q <= 1'b0;
			end
			ST_RD: begin
				if (grid_bit) begin
					hit_q <= 1'b1;
				end else begin
					x_q   <= x_q + sx_q;
					y_q   <= y_q + sy_q;
					cnt_q <= cnt_q + DEPTH_W'(1);
				end
			end
			ST_D2: acc_q <= DIST_W'(mul_p);
			ST_D3: begin
				if (!pass_q) begin
					hx_q   <= x_q;
					hy_q   <= y_q;
					hhit_q <= hit_q;
					hd_q   <= dist_sum;
					pass_q <= 1'b1;
				end else begin
					vd_q <= dist_sum;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ox_q    <= sat17(pick_h ? hx_q : x_q);
					oy_q    <= sat17(pick_h ? hy_q : y_q);
					oside_q <= !pick_h;
					owall_q <= pick_h ? hhit_q : hit_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign hit_x      = ox_q;
	assign hit_y      = oy_q;
	assign hit_side   = oside_q;
	assign wall_found = owall_q;

	`GRWH_ASSERT(a_rd_in_grid, grid_rd.en |-> grid_rd.idx < CELL_IDX_W'(GRID_DIM * GRID_DIM), "grid read outside the map")
	`GRWH_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result shown without a finished cast")
	`GRWH_ASSERT(a_hit_from_read, $rose(hit_q) |-> $past(state_q == ST_RD && grid_bit), "hit flag set without a wall read")
	`GRWH_ASSERT_NEXT(a_rd_then_test, state_q == ST_CHK && grid_rd.en, state_q == ST_RD, "grid read not followed by its test")
endmodule
`default_nettype wire

// File: sv/grid_ray_wall_hit_unit.sv
// ----------------------------------------------------------------------------
// grid_ray_wall_hit_unit
// casts a ray over a square wall grid and returns the nearer grid line crossing
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes items. s_tuser = 0 writes one grid cell and gives no
//   result; s_tuser = 1 casts a ray from pos_x/pos_y at view_angle.
//   m_* channel returns one item per cast: the crossing point, the pass that
//   chose it and whether a wall was met.
//   cfg_we/cfg_wdata set the depth limit (grid lines per pass), reset 10;
//   write it only while no cast is in flight.
// timing:
//   a cell write is done in the idle state and leaves the unit ready for the
//   next item. each active pass of a cast runs the setup states MUL1 to MUL3,
//   then CHK and RD for each grid line tested, ending on a wall, the map edge
//   or the depth limit (up to 31), then D1 to D3 for the distance; DONE picks
//   the result and returns to idle. the stepping loop runs on the single
//   shared multiplier and grid read port. s_tready is low while a cast runs.
// reset and stall:
//   reset clears all grid cells and the depth limit goes back to 10. a result
//   waits in the output register while m_tready is low; a new item can be
//   taken meanwhile, and the next cast waits before its pick until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grid_ray_wall_hit_unit #(
	parameter int GRID_DIM = grwh_pkg::GRID_DIM
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [grwh_pkg::DEPTH_W-1:0]  cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cell_index[6:0], cell_wall[7], pos_x[23:8], pos_y[39:24], view_angle[48:40]
	input  logic [55:0]                   s_tdata,
	// action[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hit_x[16:0], hit_y[33:17]
	output logic [39:0]                   m_tdata,
	// hit_side[0], wall_found[1]
	output logic [1:0]                    m_tuser
);
	import grwh_pkg::*;

	logic [DEPTH_W-1:0]       depth_q;
	grid_wr_t                 grid_wr;
	grid_rd_t                 grid_rd;
	logic                     grid_bit;
	mul_req_t                 mul_req;
	logic signed [PROD_W-1:0] mul_p;
	logic [OUT_POS_W-1:0]     hit_x, hit_y;
	logic                     hit_side, wall_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	grwh_grid #(.GRID_DIM(GRID_DIM)) u_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (grid_wr),
		.rd     (grid_rd),
		.rd_bit (grid_bit)
	);

	grwh_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.p   (mul_p)
	);

	grwh_ctrl #(.GRID_DIM(GRID_DIM)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.depth         (depth_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_action     (s_tuser),
		.in_cell_index (s_tdata[6:0]),
		.in_cell_wall  (s_tdata[7]),
		.in_pos_x      (s_tdata[23:8]),
		.in_pos_y      (s_tdata[39:24]),
		.in_view_angle (s_tdata[48:40]),
		.grid_wr       (grid_wr),
		.grid_rd       (grid_rd),
		.grid_bit      (grid_bit),
		.mul_req       (mul_req),
		.mul_p         (mul_p),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.hit_x         (hit_x),
		.hit_y         (hit_y),
		.hit_side      (hit_side),
		.wall_found    (wall_found)
	);

	assign m_tdata = {6'b0, hit_y, hit_x};
	assign m_tuser = {wall_found, hit_side};
endmodule
`default_nettype wire
